FILE: hw/rtl/date_string_validator_core_assert.svh
// Assertion macros for the date string validator.
`ifndef DATE_STRING_VALIDATOR_CORE_ASSERT_SVH
`define DATE_STRING_VALIDATOR_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define DSV_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("date validator assertion failed");

// Property checked on every clock edge, reset included.
`define DSV_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("date validator assertion failed");

`endif

FILE: hw/rtl/dsv_pkg.sv
// Package: constants, types and helpers shared by the date validator.
`default_nettype none
package dsv_pkg;

  localparam logic [3:0] DateLen   = 4'd10;
  localparam logic [3:0] PosSat    = 4'd11;
  localparam logic [3:0] SlashPosA = 4'd2;
  localparam logic [3:0] SlashPosB = 4'd5;
  localparam logic [3:0] YearLoPos = 4'd8;

  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  localparam logic [6:0] MonthFeb = 7'd2;
  localparam logic [6:0] MonthApr = 7'd4;
  localparam logic [6:0] MonthJun = 7'd6;
  localparam logic [6:0] MonthSep = 7'd9;
  localparam logic [6:0] MonthNov = 7'd11;
  localparam logic [6:0] MonthMax = 7'd12;

  localparam logic [6:0] DaysShort = 7'd30;
  localparam logic [6:0] DaysLong  = 7'd31;
  localparam logic [6:0] DaysLeap  = 7'd29;
  localparam logic [6:0] DaysFeb   = 7'd28;

  typedef struct packed {
    logic        format_error;
    logic        len_ok;
    logic        leap;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [13:0] year;
  } line_t;

  typedef struct packed {
    logic        status;
    logic [6:0]  day_value;
    logic [6:0]  month_value;
    logic [13:0] year_value;
  } result_t;

  function automatic logic [6:0] month_length(input logic [6:0] month, input logic leap);
    logic [6:0] len;
    len = DaysLong;
    if (month == MonthApr || month == MonthJun || month == MonthSep || month == MonthNov) begin
      len = DaysShort;
    end else if (month == MonthFeb) begin
      len = leap ? DaysLeap : DaysFeb;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dsv_char_if.sv
// Interfaces: character input channel and verdict output channel.
`default_nettype none
interface dsv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface dsv_result_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [6:0]  day_value;
  logic [6:0]  month_value;
  logic [13:0] year_value;

  modport source (output valid, output status, output day_value, output month_value,
                  output year_value, input ready);
  modport sink   (input valid, input status, input day_value, input month_value,
                  input year_value, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/dsv_line_parser.sv
// Line parser: position counter, field accumulators and format error flag.
`default_nettype none
module dsv_line_parser
  import dsv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] char_code,
  input  wire logic       end_of_line,
  output line_t           line
);

  logic [3:0]  pos, pos_next;
  logic [6:0]  day, day_next;
  logic [6:0]  month, month_next;
  logic [13:0] year, year_next;
  logic [6:0]  year_hi, year_hi_next;
  logic [6:0]  year_lo, year_lo_next;
  logic        ferr, ferr_next;
  logic        is_digit;
  logic [3:0]  dig;

  function automatic logic [13:0] mul10_add(input logic [13:0] v, input logic [3:0] d);
    return {v[10:0], 3'b000} + {v[12:0], 1'b0} + {10'd0, d};
  endfunction

  assign is_digit = (char_code >= CharZero) && (char_code <= CharNine);
  assign dig      = 4'(char_code - CharZero);

  always_comb begin
    pos_next     = pos;
    day_next     = day;
    month_next   = month;
    year_next    = year;
    year_hi_next = year_hi;
    year_lo_next = year_lo;
    ferr_next    = ferr;
    if (step) begin
      if (end_of_line) begin
        pos_next     = '0;
        day_next     = '0;
        month_next   = '0;
        year_next    = '0;
        year_hi_next = '0;
        year_lo_next = '0;
        ferr_next    = 1'b0;
      end else begin
        if (pos >= DateLen) begin
          ferr_next = 1'b1;
        end else if (pos == SlashPosA || pos == SlashPosB) begin
          if (char_code != CharSlash) ferr_next = 1'b1;
        end else if (!is_digit) begin
          ferr_next = 1'b1;
        end else if (pos < SlashPosA) begin
          day_next = 7'(mul10_add({7'd0, day}, dig));
        end else if (pos < SlashPosB) begin
          month_next = 7'(mul10_add({7'd0, month}, dig));
        end else begin
          year_next = mul10_add(year, dig);
          if (pos < YearLoPos) year_hi_next = 7'(mul10_add({7'd0, year_hi}, dig));
          else                 year_lo_next = 7'(mul10_add({7'd0, year_lo}, dig));
        end
        if (pos < PosSat) pos_next = pos + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      day     <= '0;
      month   <= '0;
      year    <= '0;
      year_hi <= '0;
      year_lo <= '0;
      ferr    <= 1'b0;
    end else begin
      pos     <= pos_next;
      day     <= day_next;
      month   <= month_next;
      year    <= year_next;
      year_hi <= year_hi_next;
      year_lo <= year_lo_next;
      ferr    <= ferr_next;
    end
  end

  // Leap: low pair nonzero -> low pair divisible by 4; else century divisible by 4.
  always_comb begin
    line.format_error = ferr;
    line.len_ok       = (pos == DateLen);
    line.leap         = (year_lo != 7'd0) ? (year_lo[1:0] == 2'b00) : (year_hi[1:0] == 2'b00);
    line.day          = day;
    line.month        = month;
    line.year         = year;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dsv_verdict.sv
// Verdict logic: format and length flags, month range and day-of-month check on the parsed line.
`default_nettype none
module dsv_verdict
  import dsv_pkg::*;
(
  input  wire line_t line,
  output result_t    result
);

  logic       ok;
  logic [6:0] mlen;

  assign mlen = month_length(line.month, line.leap);
  assign ok   = !line.format_error && line.len_ok
             && (line.month >= 7'd1) && (line.month <= MonthMax)
             && (line.day >= 7'd1) && (line.day <= mlen);

  always_comb begin
    result.status      = !ok;
    result.day_value   = ok ? line.day   : '0;
    result.month_value = ok ? line.month : '0;
    result.year_value  = ok ? line.year  : '0;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/date_string_validator_core.sv
// DD/MM/YYYY date line validator, one character per beat, verdict on end-of-line.
// Takes one beat per clock cycle without pause while results are taken. Each beat
// lands in an input register and is applied to the line state from there; an
// end-of-line beat also loads the result register, where the verdict is held. A
// held result stalls only an end-of-line beat waiting behind it; character beats
// keep flowing. The input register and the result register set the pace.
`default_nettype none
module date_string_validator_core
  import dsv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  dsv_char_if.sink     in,
  dsv_result_if.source out
);

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eol;
  logic       out_free;
  logic       drain;
  line_t      line;
  result_t    verdict;
  logic       res_valid;
  result_t    res;

  assign out_free = !res_valid || out.ready;
  assign drain    = s1_valid && (!s1_eol || out_free);
  assign in.ready = !s1_valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in.ready) begin
      s1_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      s1_char <= in.char_code;
      s1_eol  <= in.end_of_line;
    end
  end

  dsv_line_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .step       (drain),
    .char_code  (s1_char),
    .end_of_line(s1_eol),
    .line       (line)
  );

  dsv_verdict u_verdict (
    .line  (line),
    .result(verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (drain && s1_eol) begin
      res_valid <= 1'b1;
    end else if (out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain && s1_eol) begin
      res <= verdict;
    end
  end

  assign out.valid       = res_valid;
  assign out.status      = res.status;
  assign out.day_value   = res.day_value;
  assign out.month_value = res.month_value;
  assign out.year_value  = res.year_value;

endmodule
`default_nettype wire

FILE: hw/rtl/dsv_checker.sv
// Port checker for the date validator, bound to the top level.
`default_nettype none
`include "date_string_validator_core_assert.svh"
module dsv_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        status,
  input wire logic [6:0]  day_value,
  input wire logic [6:0]  month_value,
  input wire logic [13:0] year_value
);

  `DSV_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  `DSV_ASSERT(a_wrong_zero, clk, rst, out_valid && status |-> day_value == 7'd0 && month_value == 7'd0 && year_value == 14'd0)
  `DSV_ASSERT(a_valid_range, clk, rst, out_valid && !status |-> month_value >= 7'd1 && month_value <= 7'd12 && day_value >= 7'd1 && day_value <= 7'd31 && year_value <= 14'd9999)
  `DSV_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)

endmodule

bind date_string_validator_core dsv_checker u_dsv_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out.valid),
  .out_ready  (out.ready),
  .status     (out.status),
  .day_value  (out.day_value),
  .month_value(out.month_value),
  .year_value (out.year_value)
);
`default_nettype wire
